@@ rtl/gpml_pkg.sv @@
`default_nettype none

package gpml_pkg;

   // Default frame layout
   localparam int FRAME_BYTES_DEF = 9;
   localparam int ID_POS_DEF      = 1;
   localparam int BUTTON_POS_DEF  = 3;
   localparam int STICK_POS_DEF   = 5;

   // Byte positions are handed to the command table at this width (frames up to 32 bytes)
   localparam int POS_W = 5;

   // Register reset values
   localparam logic [7:0] POLL_INTERVAL_RST = 8'd15;
   localparam logic [7:0] ANALOG_ID_RST     = 8'h73;

   // Command bytes
   localparam logic [7:0] CMD_START     = 8'h01;
   localparam logic [7:0] CMD_POLL      = 8'h42;
   localparam logic [7:0] CMD_CONFIG    = 8'h43;
   localparam logic [7:0] CMD_SET_MODE  = 8'h44;
   localparam logic [7:0] CMD_ENABLE    = 8'h01;
   localparam logic [7:0] CMD_MODE_LOCK = 8'h03;
   localparam logic [7:0] CMD_IDLE      = 8'h00;

   // Stick centering
   localparam logic [7:0] STICK_MID     = 8'h7F;
   localparam logic [7:0] STICK_OFS_LO  = 8'd127;
   localparam logic [7:0] STICK_OFS_HI  = 8'd128;

   localparam logic [7:0] ELAPSED_MAX   = 8'hFF;

   localparam int CSR_INDEX_W = 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_POLL_INTERVAL = 1'b0,
      CSR_ANALOG_ID     = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      KIND_IDLE    = 3'd0,
      KIND_READ    = 3'd1,
      KIND_ENTER   = 3'd2,
      KIND_SETMODE = 3'd3,
      KIND_EXIT    = 3'd4,
      KIND_NONE    = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      ACT_NONE   = 2'd0,
      ACT_XFER   = 2'd1,
      ACT_END    = 2'd2,
      ACT_REPORT = 2'd3
   } action_type;

   typedef enum logic [0:0] {
      OP_TICK = 1'b0,
      OP_BYTE = 1'b1
   } opcode_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [7:0]  rx_byte;
   } item_type;

   typedef struct packed {
      action_type  action;
      logic [7:0]  tx_byte;
      logic [15:0] buttons;
      logic [7:0]  right_x;
      logic [7:0]  right_y;
      logic [7:0]  left_x;
      logic [7:0]  left_y;
   } result_type;

   // Command byte sent at a given position of a frame
   function automatic logic [7:0] cmd_byte(kind_type kind, logic [POS_W-1:0] pos);
      logic [7:0] b;
      b = CMD_IDLE;
      priority if (pos == POS_W'(0)) begin
         b = CMD_START;
      end else if (pos == POS_W'(1)) begin
         if (kind == KIND_READ) b = CMD_POLL;
         else if (kind == KIND_SETMODE) b = CMD_SET_MODE;
         else b = CMD_CONFIG;
      end else if (pos == POS_W'(3) && (kind == KIND_ENTER || kind == KIND_SETMODE)) begin
         b = CMD_ENABLE;
      end else if (pos == POS_W'(4) && kind == KIND_SETMODE) begin
         b = CMD_MODE_LOCK;
      end else begin
         b = CMD_IDLE;
      end
      return b;
   endfunction

   // Center a raw stick byte around zero
   function automatic logic [7:0] stick_map(logic [7:0] b);
      return (b <= STICK_MID) ? (STICK_OFS_LO - b) : (STICK_OFS_HI - b);
   endfunction

endpackage

`default_nettype wire

@@ rtl/gpml_in_stage.sv @@
`default_nettype none

module gpml_in_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire gpml_pkg::item_type in_item,
   input  wire logic              advance,
   output logic                   item_valid,
   output gpml_pkg::item_type     item
);

   logic               valid_ff;
   logic               valid_in;
   gpml_pkg::item_type item_ff;

   // Stage is free when empty or its item moves on this cycle
   assign in_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (in_ready) valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload capture on transfer
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) item_ff <= in_item;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

`default_nettype wire

@@ rtl/gpml_core.sv @@
`default_nettype none

module gpml_core #(
   parameter int FRAME_BYTES = gpml_pkg::FRAME_BYTES_DEF,
   parameter int ID_POS      = gpml_pkg::ID_POS_DEF,
   parameter int BUTTON_POS  = gpml_pkg::BUTTON_POS_DEF,
   parameter int STICK_POS   = gpml_pkg::STICK_POS_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_write_enable,
   input  wire logic [gpml_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire logic [7:0]                             csr_write_data,
   input  wire gpml_pkg::item_type                     item,
   input  wire logic                                   advance,
   output gpml_pkg::result_type                        result
);

   localparam int PW = $clog2(FRAME_BYTES);

   // Configuration registers
   logic [7:0] poll_interval_ff;
   logic [7:0] analog_id_ff;

   // Poller state
   gpml_pkg::kind_type frame_kind_ff, frame_kind_in;
   gpml_pkg::kind_type next_frame_ff, next_frame_in;
   logic [PW-1:0]      pos_ff, pos_in;
   logic [7:0]         elapsed_ff, elapsed_in;
   logic [47:0]        report_ff, report_in;
   logic [7:0]         store_ff [FRAME_BYTES];

   logic [7:0]         view [FRAME_BYTES];
   logic [PW:0]        next_pos;
   logic [7:0]         elapsed_inc;
   logic               store_we;
   gpml_pkg::action_type action;
   logic [7:0]         tx_byte;
   logic [15:0]        buttons;

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         poll_interval_ff <= gpml_pkg::POLL_INTERVAL_RST;
         analog_id_ff     <= gpml_pkg::ANALOG_ID_RST;
      end else if (csr_write_enable) begin
         unique case (gpml_pkg::csr_index_type'(csr_index))
            gpml_pkg::CSR_POLL_INTERVAL: poll_interval_ff <= csr_write_data;
            gpml_pkg::CSR_ANALOG_ID:     analog_id_ff     <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Frame bytes as they stand after the current byte lands
   always_comb begin
      for (int i = 0; i < FRAME_BYTES; i++) begin
         view[i] = (PW'(i) == pos_ff) ? item.rx_byte : store_ff[i];
      end
   end

   assign next_pos    = {1'b0, pos_ff} + (PW+1)'(1);
   assign elapsed_inc = (elapsed_ff == gpml_pkg::ELAPSED_MAX) ? elapsed_ff
                                                              : elapsed_ff + 8'd1;
   assign buttons     = ~{view[BUTTON_POS], view[BUTTON_POS+1]};

   // Next state and result
   always_comb begin
      frame_kind_in = frame_kind_ff;
      next_frame_in = next_frame_ff;
      pos_in        = pos_ff;
      elapsed_in    = elapsed_ff;
      report_in     = report_ff;
      store_we      = 1'b0;
      action        = gpml_pkg::ACT_NONE;
      tx_byte       = gpml_pkg::CMD_IDLE;
      if (item.opcode == gpml_pkg::OP_TICK) begin
         elapsed_in = elapsed_inc;
         if (frame_kind_ff == gpml_pkg::KIND_IDLE) begin
            if (next_frame_ff != gpml_pkg::KIND_NONE) begin
               // pending config frame starts at once
               frame_kind_in = next_frame_ff;
               next_frame_in = gpml_pkg::KIND_NONE;
               pos_in        = '0;
               action        = gpml_pkg::ACT_XFER;
               tx_byte       = gpml_pkg::cmd_byte(next_frame_ff, '0);
            end else if (elapsed_inc >= poll_interval_ff) begin
               elapsed_in    = '0;
               frame_kind_in = gpml_pkg::KIND_READ;
               pos_in        = '0;
               action        = gpml_pkg::ACT_XFER;
               tx_byte       = gpml_pkg::cmd_byte(gpml_pkg::KIND_READ, '0);
            end
         end
      end else if (frame_kind_ff != gpml_pkg::KIND_IDLE) begin
         store_we = 1'b1;
         if (next_pos < (PW+1)'(FRAME_BYTES)) begin
            pos_in  = next_pos[PW-1:0];
            action  = gpml_pkg::ACT_XFER;
            tx_byte = gpml_pkg::cmd_byte(frame_kind_ff, gpml_pkg::POS_W'(next_pos));
         end else begin
            // last byte of the frame: release select
            frame_kind_in = gpml_pkg::KIND_IDLE;
            pos_in        = '0;
            action        = gpml_pkg::ACT_END;
            unique case (frame_kind_ff)
               gpml_pkg::KIND_READ: begin
                  if (view[ID_POS] != analog_id_ff) begin
                     next_frame_in = gpml_pkg::KIND_ENTER;
                  end else begin
                     report_in = {buttons,
                                  gpml_pkg::stick_map(view[STICK_POS]),
                                  gpml_pkg::stick_map(view[STICK_POS+1]),
                                  gpml_pkg::stick_map(view[STICK_POS+2]),
                                  gpml_pkg::stick_map(view[STICK_POS+3])};
                     action    = gpml_pkg::ACT_REPORT;
                  end
               end
               gpml_pkg::KIND_ENTER:   next_frame_in = gpml_pkg::KIND_SETMODE;
               gpml_pkg::KIND_SETMODE: next_frame_in = gpml_pkg::KIND_EXIT;
               default:                next_frame_in = gpml_pkg::KIND_NONE;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_kind_ff <= gpml_pkg::KIND_IDLE;
         next_frame_ff <= gpml_pkg::KIND_ENTER;
         pos_ff        <= '0;
         elapsed_ff    <= '0;
         report_ff     <= '0;
      end else if (advance) begin
         frame_kind_ff <= frame_kind_in;
         next_frame_ff <= next_frame_in;
         pos_ff        <= pos_in;
         elapsed_ff    <= elapsed_in;
         report_ff     <= report_in;
      end
   end

   // Received bytes
   always_ff @(posedge clock) begin
      if (advance && store_we) store_ff[pos_ff] <= item.rx_byte;
   end

   assign result.action  = action;
   assign result.tx_byte = tx_byte;
   assign result.buttons = report_in[47:32];
   assign result.right_x = report_in[31:24];
   assign result.right_y = report_in[23:16];
   assign result.left_x  = report_in[15:8];
   assign result.left_y  = report_in[7:0];

endmodule

`default_nettype wire

@@ rtl/gpml_out_reg.sv @@
`default_nettype none

module gpml_out_reg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  wire gpml_pkg::result_type load_data,
   output logic                      can_load,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output gpml_pkg::result_type      out_data
);

   logic                 valid_ff;
   logic                 valid_in;
   gpml_pkg::result_type data_ff;

   // Free when empty or the held result transfers now
   assign can_load = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      if (can_load) valid_in = load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) data_ff <= load_data;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

@@ rtl/gamepad_poll_and_mode_lock.sv @@
// A request is held in the input stage, and its response is held in the result register.
// Throughput: one request per cycle while rsp_ready applies no backpressure; each request gives exactly one response.
// Backpressure on rsp_ready stalls both stages; the input stage then accepts a request only while it is empty.
// Reset (synchronous, active high) clears the pipeline, loads register defaults, leaves the
// poller idle with the config sequence pending and clears the report; stored frame bytes stay.
`default_nettype none

module gamepad_poll_and_mode_lock #(
   parameter int FRAME_BYTES = gpml_pkg::FRAME_BYTES_DEF,
   parameter int ID_POS      = gpml_pkg::ID_POS_DEF,
   parameter int BUTTON_POS  = gpml_pkg::BUTTON_POS_DEF,
   parameter int STICK_POS   = gpml_pkg::STICK_POS_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_write_enable,
   input  wire logic [gpml_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [7:0]                       csr_write_data,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic                             req_opcode,
   input  wire logic [7:0]                       req_rx_byte,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [1:0]                            rsp_action,
   output logic [7:0]                            rsp_tx_byte,
   output logic [15:0]                           rsp_buttons,
   output logic signed [7:0]                     rsp_right_x,
   output logic signed [7:0]                     rsp_right_y,
   output logic signed [7:0]                     rsp_left_x,
   output logic signed [7:0]                     rsp_left_y
);

   gpml_pkg::item_type   in_item;
   gpml_pkg::item_type   item;
   gpml_pkg::result_type result;
   gpml_pkg::result_type out_data;
   logic                 item_valid;
   logic                 can_load;
   logic                 advance;

   assign in_item.opcode  = gpml_pkg::opcode_type'(req_opcode);
   assign in_item.rx_byte = req_rx_byte;

   // Held item is processed when the result register can take it
   assign advance = item_valid && can_load;

   gpml_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_item    (in_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   gpml_core #(
      .FRAME_BYTES (FRAME_BYTES),
      .ID_POS      (ID_POS),
      .BUTTON_POS  (BUTTON_POS),
      .STICK_POS   (STICK_POS)
   ) u_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .item             (item),
      .advance          (advance),
      .result           (result)
   );

   gpml_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance),
      .load_data (result),
      .can_load  (can_load),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_data)
   );

   assign rsp_action  = out_data.action;
   assign rsp_tx_byte = out_data.tx_byte;
   assign rsp_buttons = out_data.buttons;
   assign rsp_right_x = out_data.right_x;
   assign rsp_right_y = out_data.right_y;
   assign rsp_left_x  = out_data.left_x;
   assign rsp_left_y  = out_data.left_y;

endmodule

`default_nettype wire
